// ===== design/rational_normalizer_assert.svh =====
// rational_normalizer_assert.svh: assertion macros shared by the rational normalizer modules
// expects clk and rst_n in the scope where a macro is used
`ifndef RATIONAL_NORMALIZER_ASSERT_SVH
`define RATIONAL_NORMALIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rn_pkg.sv =====
// rn_pkg.sv: widths, command and status types and helpers for the rational normalizer
// no dependencies
package rn_pkg;

    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a new fraction
        logic gcd_step;  // one binary gcd step, or latch the gcd when done
        logic div_step;  // one restoring division step
        logic div_swap;  // keep the numerator quotient, restart on the denominator
        logic publish;   // load the output register
    } rn_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic err;       // denominator was zero
        logic gcd_done;
        logic div_last;
    } rn_status_t;

    // unsigned magnitude of a two's complement word
    function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] x);
        mag_of = x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
    endfunction

endpackage

// ===== design/rn_frac_if.sv =====
// rn_frac_if.sv: input channel carrying one signed fraction
// depends on rn_pkg
interface rn_frac_if
    import rn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] numerator;
    logic signed [WORD_W-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// ===== design/rn_result_if.sv =====
// rn_result_if.sv: output channel carrying one reduced fraction
// depends on rn_pkg
interface rn_result_if
    import rn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     status;
    logic                     is_whole;
    logic signed [WORD_W-1:0] reduced_numerator;
    logic        [WORD_W-1:0] reduced_denominator;

    modport source (output valid, output status, output is_whole,
                    output reduced_numerator, output reduced_denominator, input ready);
    modport sink   (input valid, input status, input is_whole,
                    input reduced_numerator, input reduced_denominator, output ready);
endinterface

// ===== design/rational_normalizer.sv =====
// rational_normalizer.sv: top level, reduces a signed 64-bit fraction to lowest terms
// depends on rn_pkg, rn_frac_if, rn_result_if, rn_ctrl and rn_datapath
//
// frac carries numerator and denominator in two's complement; a transfer happens on a
// rising edge with valid and ready high. reduced carries status, is_whole,
// reduced_numerator and reduced_denominator (unsigned magnitude) under the same rule.
// Each fraction gives exactly one result. A zero denominator sets status and zeroes
// the other fields.
// Sequence: capture, then the binary gcd at one shift or subtract-and-shift step per
// cycle (how many steps depends on the operands), then the two restoring divisions by
// the gcd, numerator first, on the shared divider, then the output register.
// A zero denominator skips the divisions.
// One fraction is in work at a time; frac.ready is high only while idle, and a new
// fraction may enter while the previous result still waits in the output register.
// If reduced.ready stays low, the finished fraction waits until the register frees.
// Reset (rst_n, asynchronous, active low) drops any fraction in work and any pending
// result and returns to idle.
module rational_normalizer
    import rn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rn_frac_if.sink      frac,
    rn_result_if.source  reduced
);

    rn_cmd_t    cmd;
    rn_status_t status;

    rn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frac.valid),
        .in_ready  (frac.ready),
        .out_valid (reduced.valid),
        .out_ready (reduced.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rn_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .numerator       (frac.numerator),
        .denominator     (frac.denominator),
        .cmd             (cmd),
        .status          (status),
        .res_status      (reduced.status),
        .res_is_whole    (reduced.is_whole),
        .res_numerator   (reduced.reduced_numerator),
        .res_denominator (reduced.reduced_denominator)
    );

endmodule

// ===== design/rn_ctrl.sv =====
// rn_ctrl.sv: sequencing state machine for the rational normalizer
// depends on rn_pkg and rational_normalizer_assert.svh
`include "rational_normalizer_assert.svh"

module rn_ctrl
    import rn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  rn_status_t status,
    output rn_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_GCD    = 5'b00010,
        ST_DIVN   = 5'b00100,
        ST_DIVD   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                cmd.gcd_step = 1'b1;
                if (status.gcd_done)
                begin
                    state_next = status.err ? ST_FINISH : ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    cmd.div_swap = 1'b1;
                    state_next   = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // checks
    `RN_ASSERT_NOW(a_publish_slot, cmd.publish, slot_free, "result published over a pending result")
    `RN_ASSERT_NEXT(a_accept_to_gcd, in_valid && in_ready, state_reg == ST_GCD, "accept did not start gcd")
    `RN_ASSERT_NEXT(a_err_skips_div, (state_reg == ST_GCD) && status.err && status.gcd_done, state_reg == ST_FINISH, "zero denominator entered division")
    `RN_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid_reg && (state_reg == ST_IDLE), "publish did not raise valid")

endmodule

// ===== design/rn_datapath.sv =====
// rn_datapath.sv: magnitudes, binary gcd, shared restoring divider and output register
// depends on rn_pkg and rational_normalizer_assert.svh
`include "rational_normalizer_assert.svh"

module rn_datapath
    import rn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic        [WORD_W-1:0] numerator,
    input  logic        [WORD_W-1:0] denominator,
    input  rn_cmd_t                  cmd,
    output rn_status_t               status,
    output logic                     res_status,
    output logic                     res_is_whole,
    output logic signed [WORD_W-1:0] res_numerator,
    output logic        [WORD_W-1:0] res_denominator
);

    logic [WORD_W-1:0] nm_reg, dm_reg;
    logic [WORD_W-1:0] a_reg, b_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [WORD_W-1:0] g_reg;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] qn_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg, err_reg;

    logic              gcd_done;
    logic [WORD_W:0]   rem_shift, rem_diff;
    logic              fits;

    assign gcd_done        = err_reg || (a_reg == '0) || (b_reg == '0);
    assign status.err      = err_reg;
    assign status.gcd_done = gcd_done;
    assign status.div_last = (cnt_reg == CNT_LAST);

    // one restoring division step by the gcd
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WORD_W-1]};
        rem_diff  = rem_shift - {1'b0, g_reg};
        fits      = (rem_shift >= {1'b0, g_reg});
        rem_next  = fits ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
        quo_next  = {quo_reg[WORD_W-2:0], fits};
    end

    // capture, gcd iteration and division
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nm_reg  <= mag_of(numerator);
            dm_reg  <= mag_of(denominator);
            a_reg   <= mag_of(numerator);
            b_reg   <= mag_of(denominator);
            k_reg   <= '0;
            neg_reg <= numerator[WORD_W-1] ^ denominator[WORD_W-1];
            err_reg <= (denominator == '0);
        end
        else if (cmd.gcd_step)
        begin
            if (gcd_done)
            begin
                // the common power of two goes back onto the odd part
                g_reg   <= (a_reg | b_reg) << k_reg;
                quo_reg <= nm_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + CNT_W'(1);
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_reg <= (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end
        else if (cmd.div_swap)
        begin
            qn_reg  <= quo_next;
            quo_reg <= dm_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // output register, quo_reg holds the reduced denominator here
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            res_status      <= err_reg;
            res_is_whole    <= !err_reg && (quo_reg == WORD_W'(1));
            res_numerator   <= err_reg ? '0 : (neg_reg ? (~qn_reg + WORD_W'(1)) : qn_reg);
            res_denominator <= err_reg ? '0 : quo_reg;
        end
    end

    // checks
    `RN_ASSERT_NOW(a_rem_below_gcd, cmd.div_step, rem_reg < g_reg, "division remainder not below gcd")
    `RN_ASSERT_NEXT(a_gcd_nonzero, cmd.gcd_step && gcd_done && !err_reg, g_reg != '0, "gcd latched as zero")
    `RN_ASSERT_NEXT(a_err_zeroes, cmd.publish && err_reg, res_status && (res_denominator == '0) && (res_numerator == '0), "error result not cleared")

endmodule

// ===== tb/sv/reduced_fraction_checker.sv =====
// reduced_fraction_checker.sv: watches the fraction and result channels of rational_normalizer,
// reduces each accepted fraction itself and compares every result transfer field by field
// depends on rn_pkg
module reduced_fraction_checker
    import rn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     frac_valid,
    input  logic                     frac_ready,
    input  logic signed [WORD_W-1:0] numerator,
    input  logic signed [WORD_W-1:0] denominator,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic                     status,
    input  logic                     is_whole,
    input  logic signed [WORD_W-1:0] reduced_numerator,
    input  logic        [WORD_W-1:0] reduced_denominator,
    output int                       mismatches,
    output int                       outstanding
);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    typedef struct packed {
        logic                     status;
        logic                     is_whole;
        logic signed [WORD_W-1:0] num;
        logic        [WORD_W-1:0] den;
    } lowest_terms_t;

    lowest_terms_t expected_terms[$];
    lowest_terms_t oldest;
    logic          field_bad;

    // fraction in lowest terms: magnitudes over their euclidean gcd, sign from the xor
    function automatic lowest_terms_t lowest_terms(input logic [WORD_W-1:0] n,
                                                   input logic [WORD_W-1:0] d);
        lowest_terms_t     r;
        logic              negative;
        logic [WORD_W-1:0] n_mag;
        logic [WORD_W-1:0] d_mag;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] rem;
        r = '0;
        if (d == '0)
        begin
            r.status = STATUS_DIV_ZERO;
            return r;
        end
        negative = n[WORD_W-1] ^ d[WORD_W-1];
        n_mag    = n[WORD_W-1] ? (~n + WORD_W'(1)) : n;
        d_mag    = d[WORD_W-1] ? (~d + WORD_W'(1)) : d;
        a        = n_mag;
        b        = d_mag;
        while (b != '0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        // d_mag is nonzero here, so the gcd is too
        n_mag      = n_mag / a;
        d_mag      = d_mag / a;
        r.status   = STATUS_OK;
        r.is_whole = (d_mag == WORD_W'(1));
        r.num      = negative ? (~n_mag + WORD_W'(1)) : n_mag;
        r.den      = d_mag;
        return r;
    endfunction

    // result transfers are checked before the fraction of the same edge is queued
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_terms.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: %0b %0b %0d / %0d",
                             $time, status, is_whole, reduced_numerator, reduced_denominator);
                    mismatches++;
                end
                else
                begin
                    oldest    = expected_terms.pop_front();
                    field_bad = 1'b0;
                    if (status !== oldest.status)
                        $display("%0t: status expected %0b actual %0b",
                                 $time, oldest.status, status);
                    if (is_whole !== oldest.is_whole)
                        $display("%0t: is_whole expected %0b actual %0b",
                                 $time, oldest.is_whole, is_whole);
                    if (reduced_numerator !== oldest.num)
                        $display("%0t: reduced_numerator expected %0d actual %0d",
                                 $time, oldest.num, reduced_numerator);
                    if (reduced_denominator !== oldest.den)
                        $display("%0t: reduced_denominator expected %0d actual %0d",
                                 $time, oldest.den, reduced_denominator);
                    field_bad = (status !== oldest.status) || (is_whole !== oldest.is_whole)
                             || (reduced_numerator !== oldest.num)
                             || (reduced_denominator !== oldest.den);
                    if (field_bad)
                        mismatches++;
                end
            end
            if (frac_valid && frac_ready)
                expected_terms.push_back(lowest_terms(numerator, denominator));
        end
        outstanding <= expected_terms.size();
    end

endmodule

// ===== tb/sv/tb_rational_normalizer.sv =====
// tb_rational_normalizer.sv: top of the rational_normalizer testbench, drives fractions with
// random gaps and result stalls, and gives the verdict from reduced_fraction_checker
// depends on rn_pkg, rn_frac_if, rn_result_if, rational_normalizer and reduced_fraction_checker
module tb_rational_normalizer;
    import rn_pkg::*;

    localparam logic [WORD_W-1:0] MOST_NEG  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] MOST_POS  = ~MOST_NEG;
    localparam logic [WORD_W-1:0] MINUS_ONE = '1;
    localparam int RANDOM_FRACTIONS = 1600;
    localparam int DRAIN_CYCLES     = 300;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   stall_left;
    bit   steady;

    rn_frac_if   frac_ch();
    rn_result_if result_ch();

    rational_normalizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frac    (frac_ch),
        .reduced (result_ch)
    );

    reduced_fraction_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .frac_valid          (frac_ch.valid),
        .frac_ready          (frac_ch.ready),
        .numerator           (frac_ch.numerator),
        .denominator         (frac_ch.denominator),
        .res_valid           (result_ch.valid),
        .res_ready           (result_ch.ready),
        .status              (result_ch.status),
        .is_whole            (result_ch.is_whole),
        .reduced_numerator   (result_ch.reduced_numerator),
        .reduced_denominator (result_ch.reduced_denominator),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #40000000;
        $display("rational_normalizer test failed");
        $finish;
    end

    // result side: short random stalls, now and then a long one, none in the steady stretch
    // a stall starts only rarely
    initial
    begin
        result_ch.ready = 1'b0;
        stall_left      = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < 6)
            begin
                stall_left = ($urandom_range(99) == 0) ? $urandom_range(20, 300)
                                                       : $urandom_range(0, 3);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // random word of the given bit length
    function automatic logic [WORD_W-1:0] rand_bits(input int w);
        logic [WORD_W-1:0] v;
        v = {$urandom, $urandom};
        if (w < WORD_W)
            v = v & ((WORD_W'(1) << w) - WORD_W'(1));
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] extreme_value();
        case ($urandom_range(6))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS_ONE;
            3: return WORD_W'(1);
            4: return '0;
            5: return MOST_NEG >> 1;
            default: return rand_bits(WORD_W);
        endcase
    endfunction

    // one fraction; valid stays up after the transfer for a back-to-back follower
    task automatic send_fraction(input logic [WORD_W-1:0] n, input logic [WORD_W-1:0] d);
        if (!steady && $urandom_range(99) < 20)
        begin
            frac_ch.valid <= 1'b0;
            repeat (($urandom_range(19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 8))
                @(posedge clk);
        end
        frac_ch.valid       <= 1'b1;
        frac_ch.numerator   <= n;
        frac_ch.denominator <= d;
        do
            @(posedge clk);
        while (!frac_ch.ready);
    endtask

    // mostly fractions with a shared factor so the gcd does real work
    task automatic send_random();
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] g;
        int                pick;
        pick = $urandom_range(99);
        g    = rand_bits($urandom_range(1, 32));
        if (pick < 4)
        begin
            n = rand_bits($urandom_range(0, 64));
            d = '0;
        end
        else if (pick < 8)
        begin
            n = '0;
            d = rand_bits($urandom_range(1, 64));
        end
        else if (pick < 14)
        begin
            n = extreme_value();
            d = extreme_value();
        end
        else if (pick < 40)
        begin
            n = rand_bits($urandom_range(1) ? WORD_W : $urandom_range(1, 64));
            d = rand_bits($urandom_range(1) ? WORD_W : $urandom_range(1, 64));
        end
        else if (pick < 55)
        begin
            // whole-number results
            n = g * rand_bits($urandom_range(0, 31));
            d = g;
        end
        else
        begin
            n = g * rand_bits($urandom_range(1, 31));
            d = g * rand_bits($urandom_range(1, 31));
        end
        if ($urandom_range(1))
            n = ~n + WORD_W'(1);
        if ($urandom_range(1))
            d = ~d + WORD_W'(1);
        send_fraction(n, d);
    endtask

    // hold the sender until every result is back
    task automatic wait_drained();
        frac_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // reset, directed fractions, random fractions, verdict
    initial
    begin
        rst_n               = 1'b0;
        steady              = 1'b0;
        frac_ch.valid       = 1'b0;
        frac_ch.numerator   = '0;
        frac_ch.denominator = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero denominator
        send_fraction(WORD_W'(5), '0);
        send_fraction(MOST_NEG, '0);
        send_fraction('0, '0);
        // zero numerator, any signs
        send_fraction('0, WORD_W'(7));
        send_fraction('0, ~WORD_W'(6));
        send_fraction('0, MOST_NEG);
        send_fraction('0, WORD_W'(1));
        // numerator magnitude 2^63; a positive result of magnitude 2^63 wraps
        send_fraction(MOST_NEG, MINUS_ONE);
        send_fraction(MOST_NEG, WORD_W'(1));
        send_fraction(MOST_NEG, MOST_NEG);
        send_fraction(MOST_NEG, WORD_W'(2));
        send_fraction(MOST_NEG, WORD_W'(3));
        // denominator magnitude 2^63 survives as unsigned
        send_fraction(MOST_POS, MOST_NEG);
        send_fraction(WORD_W'(1), MOST_NEG);
        // signs and ordinary reductions
        send_fraction(WORD_W'(6), ~WORD_W'(3));
        send_fraction(~WORD_W'(5), ~WORD_W'(3));
        send_fraction(WORD_W'(12), WORD_W'(3));
        send_fraction(MINUS_ONE, MINUS_ONE);
        send_fraction(WORD_W'(7), WORD_W'(13));
        send_fraction(MOST_POS, MOST_POS);
        send_fraction(MOST_POS, MINUS_ONE);
        send_fraction(WORD_W'(1), MOST_POS);
        send_fraction(MOST_POS, WORD_W'(1));
        wait_drained();

        for (int i = 0; i < RANDOM_FRACTIONS; i++)
        begin
            steady = (i >= 500 && i < 800);
            if (i == 900)
                wait_drained();
            send_random();
        end
        frac_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("rational_normalizer test passed");
        else
            $display("rational_normalizer test failed");
        $finish;
    end

endmodule
